// ----- design/lkm_pkg.sv -----
// ----------------------------------------------------------------------------
// lkm_pkg
// Shared types and constants for the ladder keyboard to note packet block:
// payload structs, ladder bin boundaries, packet codes and settle states.
// ----------------------------------------------------------------------------
package lkm_pkg;

    localparam int BIN_BOUNDARY_COUNT = 11;
    localparam int TABLE_SLOTS        = 16;
    localparam int BIN_W              = $clog2(TABLE_SLOTS);

    localparam int LEVEL_W  = 10;
    localparam int NOTE_W   = 7;
    localparam int TICK_W   = 32;
    localparam int CODE_W   = 4;
    localparam int STATUS_W = 8;
    localparam int VEL_W    = 7;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_TICKS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_NOTE    = 1'b1;

    localparam logic [TICK_W-1:0] SETTLE_RESET = 32'd40000;
    localparam logic [NOTE_W-1:0] BASE_RESET   = 7'd69;

    localparam logic [NOTE_W-1:0]   NO_KEY         = 7'd9;
    localparam logic [NOTE_W-1:0]   LADDER_ONE_TOP = 7'd9;
    localparam logic [NOTE_W-1:0]   LADDER_TWO_LOW = 7'd10;
    localparam logic [NOTE_W-1:0]   OCTAVE_STEP    = 7'd12;
    localparam logic [CODE_W-1:0]   CODE_RELEASE   = 4'd8;
    localparam logic [CODE_W-1:0]   CODE_PRESS     = 4'd9;
    localparam logic [STATUS_W-1:0] STATUS_NOTE_ON = 8'h90;
    localparam logic [VEL_W-1:0]    VEL_RELEASE    = 7'd0;
    localparam logic [VEL_W-1:0]    VEL_PRESS      = 7'h7F;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // ascending ladder boundaries, spare slots are zero and add no bins
    localparam logic [LEVEL_W-1:0] BOUNDS [TABLE_SLOTS] = '{
        10'd0,   10'd59,  10'd165, 10'd249, 10'd368, 10'd500, 10'd588, 10'd707,
        10'd823, 10'd895, 10'd978, 10'd0,   10'd0,   10'd0,   10'd0,   10'd0
    };

    typedef struct packed {
        logic [LEVEL_W-1:0] ladder_one_level;
        logic [LEVEL_W-1:0] ladder_two_level;
        logic               octave_pressed;
        logic [TICK_W-1:0]  now_ticks;
    } t_in_item;

    typedef struct packed {
        logic [CODE_W-1:0]   code_index;
        logic [STATUS_W-1:0] status_byte;
        logic [NOTE_W-1:0]   note_number;
        logic [VEL_W-1:0]    velocity;
        logic                last_of_run;
    } t_out_item;

    typedef struct packed {
        logic             hit;
        logic [BIN_W-1:0] bin;
    } t_class;

    typedef enum logic {
        MODE_SUSTAIN,
        MODE_CHANGING
    } t_mode;

    // first boundary above the level gives the bin
    function automatic t_class classify(logic [LEVEL_W-1:0] level);
        t_class res;
        res = '0;
        for (int i = BIN_BOUNDARY_COUNT - 1; i >= 1; i--) begin
            if (level < BOUNDS[i]) begin
                res.hit = 1'b1;
                res.bin = BIN_W'(i - 1);
            end
        end
        return res;
    endfunction

endpackage

// ----- design/ladder_keyboard_to_midi_notes_top.sv -----
// ----------------------------------------------------------------------------
// ladder_keyboard_to_midi_notes_top
// Turns sampled resistor-ladder readings into debounced note release and
// press packets.
// ----------------------------------------------------------------------------
// Usage:
// - request channel i_valid / o_stall / i_item carries two ladder readings,
//   the octave button level and a time stamp; accepted when i_valid is high
//   and o_stall is low
// - result channel o_valid / i_stall / o_item carries packets; taken when
//   o_valid is high and i_stall is low; a request yields zero, one or two
//   packets, the final one flagged by last_of_run
// - configuration: i_cfg_we writes i_cfg_data into the register chosen by
//   i_cfg_index (settle ticks, base note); the user must write only while the
//   block is idle, since the block itself does not enforce it
// - a request is classified and settled straight from the input register once
//   the queue has room; its packets are registered into the queue and offered
// - throughput: one request per cycle while o_stall is low, as the settle update is
//   combinational; packets leave one per cycle from a four-entry queue while i_stall is low
// - o_stall rises while a request is staged and the queue has fewer than two
//   free entries; a stalled receiver therefore backs up into the request channel
// - reset clears the queue, the settle state (no key held) and loads the
//   configuration defaults of 40000 ticks and base note 69
// ----------------------------------------------------------------------------
module ladder_keyboard_to_midi_notes_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  lkm_pkg::t_in_item                    i_item,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output lkm_pkg::t_out_item                   o_item,
    input  logic                                 i_cfg_we,
    input  logic [lkm_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [lkm_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import lkm_pkg::*;

    logic [TICK_W-1:0] r_settle_ticks;
    logic [NOTE_W-1:0] r_base_note;

    logic     r_in_valid;
    t_in_item r_in;

    t_mode             r_mode, n_mode;
    logic [NOTE_W-1:0] r_held, n_held;
    logic [NOTE_W-1:0] r_prior, n_prior;
    logic [TICK_W-1:0] r_start, n_start;

    t_out_item        r_fifo [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic              room;
    logic              advance;
    logic              pop;
    t_class            cls_one, cls_two;
    logic [NOTE_W-1:0] tone_raw, tone;
    logic [TICK_W-1:0] elapsed;
    logic              settled;
    t_out_item         rel_item, press_item, first_item, second_item;
    logic [1:0]        n_push;
    logic [PTR_W-1:0]  wr_ptr_next1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle_ticks <= SETTLE_RESET;
            r_base_note    <= BASE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SETTLE_TICKS: r_settle_ticks <= i_cfg_data[TICK_W-1:0];
                CFG_BASE_NOTE:    r_base_note    <= i_cfg_data[NOTE_W-1:0];
                default:          ;
            endcase
        end
    end

    // the queue must have room for two packets before the staged request may move on
    assign room    = (r_count <= CNT_W'(FIFO_DEPTH - 2));
    assign advance = r_in_valid && room;
    assign o_stall = r_in_valid && !room;
    assign o_valid = (r_count != '0);
    assign o_item  = r_fifo[r_rd_ptr];
    assign pop     = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in <= i_item;
        end
    end

    // note classification
    always_comb begin
        cls_one = classify(r_in.ladder_one_level);
        cls_two = classify(r_in.ladder_two_level);
        priority if (cls_one.hit) begin
            tone_raw = r_base_note + LADDER_ONE_TOP - NOTE_W'(cls_one.bin);
        end else if (cls_two.hit) begin
            tone_raw = r_base_note + LADDER_TWO_LOW + NOTE_W'(cls_two.bin);
        end else begin
            tone_raw = NO_KEY;
        end
        if (tone_raw != NO_KEY && r_in.octave_pressed) begin
            tone = tone_raw + OCTAVE_STEP;
        end else begin
            tone = tone_raw;
        end
    end

    assign elapsed = r_in.now_ticks - r_start;
    assign settled = (elapsed > r_settle_ticks);

    always_comb begin
        rel_item = '{code_index: CODE_RELEASE, status_byte: STATUS_NOTE_ON,
                     note_number: r_held, velocity: VEL_RELEASE,
                     last_of_run: (tone == NO_KEY)};
        press_item = '{code_index: CODE_PRESS, status_byte: STATUS_NOTE_ON,
                       note_number: tone, velocity: VEL_PRESS,
                       last_of_run: 1'b1};
    end

    // settle machine, next state and packet pushes
    always_comb begin
        n_mode      = r_mode;
        n_held      = r_held;
        n_prior     = r_prior;
        n_start     = r_start;
        n_push      = 2'd0;
        first_item  = rel_item;
        second_item = press_item;
        if (advance) begin
            n_prior = tone;
            unique case (r_mode)
                MODE_SUSTAIN: begin
                    if (tone != r_held) begin
                        n_mode  = MODE_CHANGING;
                        n_start = r_in.now_ticks;
                    end
                end
                MODE_CHANGING: begin
                    priority if (tone == r_held) begin
                        n_mode = MODE_SUSTAIN;
                    end else if (tone != r_prior) begin
                        n_start = r_in.now_ticks;
                    end else if (settled) begin
                        n_held = tone;
                        n_mode = MODE_SUSTAIN;
                        priority if (r_held != NO_KEY && tone != NO_KEY) begin
                            n_push = 2'd2;
                        end else if (r_held != NO_KEY) begin
                            n_push = 2'd1;
                        end else if (tone != NO_KEY) begin
                            n_push     = 2'd1;
                            first_item = press_item;
                        end else begin
                            n_push = 2'd0;
                        end
                    end else begin
                        n_mode = MODE_CHANGING;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_SUSTAIN;
            r_held  <= NO_KEY;
            r_prior <= NO_KEY;
            r_start <= '0;
        end else begin
            r_mode  <= n_mode;
            r_held  <= n_held;
            r_prior <= n_prior;
            r_start <= n_start;
        end
    end

    // packet queue
    assign wr_ptr_next1 = r_wr_ptr + PTR_W'(1);

    always_ff @(posedge i_clk) begin
        if (n_push != 2'd0) begin
            r_fifo[r_wr_ptr] <= first_item;
        end
        if (n_push == 2'd2) begin
            r_fifo[wr_ptr_next1] <= second_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PTR_W'(n_push);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= r_count + CNT_W'(n_push) - CNT_W'(pop);
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(FIFO_DEPTH))
        else $error("packet queue overfilled");

    a_run_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_item.last_of_run) |-> (r_count >= CNT_W'(2)))
        else $error("release packet without its press packet queued");

    a_no_key_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_push != 2'd0) |-> (first_item.note_number != NO_KEY))
        else $error("packet carries the no-key code");

    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in)))
        else $error("staged request lost while queue full");
`endif

endmodule

// ----- test/tb_ladder_keyboard_to_midi_notes_top.sv -----
// ----------------------------------------------------------------------------
// tb_ladder_keyboard_to_midi_notes_top
// Drives ladder readings into the keyboard block, predicts the settled note
// release and press packets in the bench and checks every packet, field by
// field, with random idling on the request side and random receiver stalls outside the quiet run.
// ----------------------------------------------------------------------------
module tb_ladder_keyboard_to_midi_notes_top;
    import lkm_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PIPE_SLACK     = 4;
    localparam int END_SLACK      = 8;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_valid     = 1'b0;
    logic                  o_stall;
    t_in_item              i_item      = '0;
    logic                  o_valid;
    logic                  i_stall     = 1'b0;
    t_out_item             o_item;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_SETTLE_TICKS;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    ladder_keyboard_to_midi_notes_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_item      (o_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // bench copy of the settle machine and its registers
    logic [TICK_W-1:0] settle_reg   = SETTLE_RESET;
    logic [NOTE_W-1:0] base_reg     = BASE_RESET;
    t_mode             settle_mode  = MODE_SUSTAIN;
    logic [NOTE_W-1:0] held_note    = NO_KEY;
    logic [NOTE_W-1:0] prior_note   = NO_KEY;
    logic [TICK_W-1:0] change_start = '0;

    t_out_item         pending_packets [$];
    int                mismatch_count = 0;
    int                quiet_cycles   = 0;
    bit                calm           = 1'b0;
    logic [TICK_W-1:0] sim_ticks      = '0;

    // lowest level of each ladder bin, bin 10 is the no-key threshold
    function automatic int bin_floor(input int b);
        case (b)
            0:       return 0;
            1:       return 59;
            2:       return 165;
            3:       return 249;
            4:       return 368;
            5:       return 500;
            6:       return 588;
            7:       return 707;
            8:       return 823;
            9:       return 895;
            default: return 978;
        endcase
    endfunction

    // -1 when the reading is above every key
    function automatic int ladder_bin(input logic [LEVEL_W-1:0] level);
        int bin;
        bin = -1;
        for (int b = 9; b >= 0; b--) begin
            if (int'(level) < bin_floor(b + 1)) bin = b;
        end
        return bin;
    endfunction

    function automatic logic [LEVEL_W-1:0] key_level(input int b);
        return LEVEL_W'($urandom_range(bin_floor(b), bin_floor(b + 1) - 1));
    endfunction

    function automatic logic [LEVEL_W-1:0] idle_level();
        return LEVEL_W'($urandom_range(978, 1023));
    endfunction

    task automatic settle_request(input t_in_item it);
        logic [NOTE_W-1:0] tone;
        int                bin_one;
        int                bin_two;
        tone    = NO_KEY;
        bin_one = ladder_bin(it.ladder_one_level);
        bin_two = ladder_bin(it.ladder_two_level);
        if (bin_one >= 0) tone = base_reg + LADDER_ONE_TOP - NOTE_W'(bin_one);
        else if (bin_two >= 0) tone = base_reg + LADDER_TWO_LOW + NOTE_W'(bin_two);
        if (tone != NO_KEY && it.octave_pressed) tone = tone + OCTAVE_STEP;

        if (settle_mode == MODE_SUSTAIN) begin
            if (tone != held_note) begin
                settle_mode  = MODE_CHANGING;
                change_start = it.now_ticks;
            end
        end else if (tone == held_note) begin
            settle_mode = MODE_SUSTAIN;
        end else if (tone != prior_note) begin
            change_start = it.now_ticks;
        end else if (TICK_W'(it.now_ticks - change_start) > settle_reg) begin
            if (held_note != NO_KEY)
                pending_packets.push_back('{CODE_RELEASE, STATUS_NOTE_ON, held_note,
                                            VEL_RELEASE, tone == NO_KEY});
            if (tone != NO_KEY)
                pending_packets.push_back('{CODE_PRESS, STATUS_NOTE_ON, tone,
                                            VEL_PRESS, 1'b1});
            held_note   = tone;
            settle_mode = MODE_SUSTAIN;
        end
        prior_note = tone;
    endtask

    // returns right after the edge that took the request, valid still high
    task automatic send_reading(input logic [LEVEL_W-1:0] one, input logic [LEVEL_W-1:0] two,
                                input logic oct, input logic [TICK_W-1:0] ticks);
        t_in_item it;
        it = '{one, two, oct, ticks};
        if (!calm) begin
            while ($urandom_range(99) < 37) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid <= 1'b1;
        i_item  <= it;
        do @(posedge i_clk); while (o_stall);
        settle_request(it);
    endtask

    task automatic drain_packets(input int slack);
        i_valid <= 1'b0;
        while (pending_packets.size() != 0) @(posedge i_clk);
        repeat (slack) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        drain_packets(PIPE_SLACK);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_SETTLE_TICKS) settle_reg = data;
        else base_reg = data[NOTE_W-1:0];
    endtask

    // default registers: press held for exactly the settle time, then one tick longer, then release
    task automatic test_reset_defaults();
        send_reading(10'd0, 10'd0, 1'b0, 32'd1000);
        send_reading(10'd0, 10'd1023, 1'b0, 32'd41000);
        send_reading(10'd58, 10'd0, 1'b0, 32'd41001);
        send_reading(10'd1023, 10'd1023, 1'b0, 32'd50000);
        send_reading(10'd978, 10'd1023, 1'b0, 32'd90001);
    endtask

    // ladder two with octave, then a bouncing swap to ladder one
    task automatic test_key_swap();
        send_reading(10'd1023, 10'd977, 1'b1, 32'd100000);
        send_reading(10'd1023, 10'd977, 1'b1, 32'd140001);
        send_reading(10'd977, 10'd0, 1'b0, 32'd150000);
        send_reading(10'd600, 10'd0, 1'b0, 32'd151000);
        send_reading(10'd895, 10'd0, 1'b0, 32'd152000);
        send_reading(10'd900, 10'd0, 1'b0, 32'd192001);
        // short excursion that returns to the held key
        send_reading(10'd0, 10'd0, 1'b0, 32'd200000);
        send_reading(10'd977, 10'd0, 1'b0, 32'd200001);
    endtask

    task automatic test_settle_extremes();
        write_reg(CFG_SETTLE_TICKS, 32'd0);
        send_reading(10'd500, 10'd0, 1'b0, 32'd300000);
        send_reading(10'd587, 10'd0, 1'b0, 32'd300000);
        send_reading(10'd500, 10'd0, 1'b0, 32'd300001);
        write_reg(CFG_SETTLE_TICKS, 32'hFFFF_FFFF);
        send_reading(10'd1023, 10'd1023, 1'b0, 32'd400000);
        send_reading(10'd1023, 10'd1023, 1'b0, 32'd399999);
    endtask

    // elapsed time taken across the counter wrap
    task automatic test_time_wrap();
        write_reg(CFG_SETTLE_TICKS, 32'd100);
        send_reading(10'd250, 10'd0, 1'b0, 32'hFFFF_FFC0);
        send_reading(10'd367, 10'd0, 1'b0, 32'h0000_0030);
    endtask

    // note arithmetic wrapping onto the no-key code and past 127
    task automatic test_base_wrap();
        write_reg(CFG_SETTLE_TICKS, 32'd0);
        write_reg(CFG_BASE_NOTE, 32'h5A5A_5A00);
        send_reading(10'd0, 10'd0, 1'b0, 32'd1000);
        send_reading(10'd10, 10'd0, 1'b0, 32'd1001);
        write_reg(CFG_BASE_NOTE, 32'd127);
        send_reading(10'd1023, 10'd0, 1'b1, 32'd2000);
        send_reading(10'd1023, 10'd58, 1'b1, 32'd2001);
        write_reg(CFG_BASE_NOTE, 32'd120);
        send_reading(10'd0, 10'd1023, 1'b1, 32'd3000);
        send_reading(10'd0, 10'd1023, 1'b1, 32'd3001);
        write_reg(CFG_BASE_NOTE, 32'd116);
        send_reading(10'd0, 10'd600, 1'b1, 32'd4000);
        send_reading(10'd0, 10'd600, 1'b1, 32'd4001);
    endtask

    // mostly held keys with random timing, some fully random readings
    task automatic test_random_playing(input int count, input logic [TICK_W-1:0] settle,
                                       input logic [NOTE_W-1:0] base, input bit quiet);
        int                 sent;
        int                 key;
        int                 hold;
        logic               oct;
        logic [TICK_W-1:0]  step;
        logic [LEVEL_W-1:0] one;
        logic [LEVEL_W-1:0] two;
        write_reg(CFG_SETTLE_TICKS, settle);
        write_reg(CFG_BASE_NOTE, {{(CFG_DATA_W - NOTE_W){1'b0}}, base});
        calm = quiet;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(99) < 15) begin
                sim_ticks = $urandom;
                send_reading(LEVEL_W'($urandom_range(0, 1023)), LEVEL_W'($urandom_range(0, 1023)),
                             1'($urandom_range(0, 1)), sim_ticks);
                sent++;
            end else begin
                key  = $urandom_range(0, 20);
                oct  = 1'($urandom_range(0, 1));
                hold = $urandom_range(1, 6);
                repeat (hold) begin
                    if ($urandom_range(3) == 0) step = settle + $urandom_range(0, 2);
                    else step = $urandom_range(0, settle / 2 + 1);
                    sim_ticks = sim_ticks + step;
                    if (key < 10) begin
                        one = key_level(key);
                        two = LEVEL_W'($urandom_range(0, 1023));
                    end else if (key < 20) begin
                        one = idle_level();
                        two = key_level(key - 10);
                    end else begin
                        one = idle_level();
                        two = idle_level();
                    end
                    send_reading(one, two, oct, sim_ticks);
                    sent++;
                end
            end
        end
        calm = 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (calm) i_stall <= 1'b0;
        else i_stall <= ($urandom_range(99) < 37);
    end

    always @(posedge i_clk) begin : check_packets
        t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_packets.size() == 0) begin
                $error("unexpected packet %h", o_item);
                mismatch_count++;
            end else begin
                want = pending_packets.pop_front();
                if (o_item.code_index !== want.code_index) begin
                    $error("code_index: expected %0d, got %0d", want.code_index, o_item.code_index);
                    mismatch_count++;
                end
                if (o_item.status_byte !== want.status_byte) begin
                    $error("status_byte: expected %0h, got %0h", want.status_byte,
                           o_item.status_byte);
                    mismatch_count++;
                end
                if (o_item.note_number !== want.note_number) begin
                    $error("note_number: expected %0d, got %0d", want.note_number,
                           o_item.note_number);
                    mismatch_count++;
                end
                if (o_item.velocity !== want.velocity) begin
                    $error("velocity: expected %0d, got %0d", want.velocity, o_item.velocity);
                    mismatch_count++;
                end
                if (o_item.last_of_run !== want.last_of_run) begin
                    $error("last_of_run: expected %0d, got %0d", want.last_of_run,
                           o_item.last_of_run);
                    mismatch_count++;
                end
            end
        end
    end

    // no request, packet or register write for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_key_swap();
        test_settle_extremes();
        test_time_wrap();
        test_base_wrap();

        test_random_playing(350, TICK_W'($urandom_range(10, 200)), 7'd24, 1'b0);
        test_random_playing(300, TICK_W'($urandom_range(10, 200)), 7'd96, 1'b1);
        test_random_playing(250, 32'd0, NOTE_W'($urandom_range(0, 127)), 1'b0);
        test_random_playing(300, TICK_W'($urandom_range(1000, 100000)),
                            NOTE_W'($urandom_range(24, 96)), 1'b0);

        drain_packets(END_SLACK);
        if (mismatch_count == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

endmodule
